/* rtl/sidec_pkg.sv */
// ----------------------------------------------------------------------------
// sidec_pkg
// shared constants and controller/datapath interface types for the signed
// integer to decimal ascii converter
// ----------------------------------------------------------------------------
package sidec_pkg;

    localparam int VALUE_W   = 32;                 // input integer width
    localparam int DIGITS    = 10;                 // max decimal digits of 2^32-1
    localparam int BCD_W     = 4 * DIGITS;         // packed bcd width
    localparam int ITER_W    = $clog2(VALUE_W);    // shift iteration counter
    localparam int NDIG_W    = $clog2(DIGITS + 1); // digit count, holds DIGITS
    localparam int CHAR_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D; // '-'

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(VALUE_W - 1);

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input, form magnitude
        logic conv_step;  // one double-dabble iteration
        logic digit_step; // drop the top digit
        logic sign_sel;   // output shows the minus sign
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic conv_last;  // current iteration is the final one
        logic top_zero;   // top bcd digit is zero
        logic one_left;   // only one digit remains
        logic negative;   // captured value was negative
    } dp_status_t;

endpackage

/* rtl/sidec_datapath.sv */
// ----------------------------------------------------------------------------
// sidec_datapath
// magnitude capture, shift-and-add-3 binary to bcd conversion and digit
// output shifter
// ----------------------------------------------------------------------------
module sidec_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sidec_pkg::VALUE_W-1:0]       value,
    input  sidec_pkg::dp_cmd_t                  cmd,
    output sidec_pkg::dp_status_t               status,
    output logic [sidec_pkg::CHAR_W-1:0]        character
);

    logic [sidec_pkg::VALUE_W-1:0] bin_reg,  bin_next;
    logic [sidec_pkg::BCD_W-1:0]   bcd_reg,  bcd_next;
    logic [sidec_pkg::ITER_W-1:0]  iter_reg, iter_next;
    logic [sidec_pkg::NDIG_W-1:0]  ndig_reg, ndig_next;
    logic                          neg_reg,  neg_next;
    logic [sidec_pkg::BCD_W-1:0]   bcd_adj;
    logic [3:0]                    top_digit;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < sidec_pkg::DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign top_digit = bcd_reg[sidec_pkg::BCD_W-1 -: 4];

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        iter_next = iter_reg;
        ndig_next = ndig_reg;
        neg_next  = neg_reg;
        if (cmd.load)
        begin
            neg_next  = value[sidec_pkg::VALUE_W-1];
            bin_next  = value[sidec_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
            bcd_next  = '0;
            iter_next = '0;
            ndig_next = sidec_pkg::NDIG_W'(sidec_pkg::DIGITS);
        end
        else if (cmd.conv_step)
        begin
            bcd_next  = {bcd_adj[sidec_pkg::BCD_W-2:0], bin_reg[sidec_pkg::VALUE_W-1]};
            bin_next  = {bin_reg[sidec_pkg::VALUE_W-2:0], 1'b0};
            iter_next = iter_reg + 1'b1;
        end
        else if (cmd.digit_step)
        begin
            bcd_next  = {bcd_reg[sidec_pkg::BCD_W-5:0], 4'd0};
            ndig_next = ndig_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            ndig_reg <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            ndig_reg <= ndig_next;
            neg_reg  <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign status.conv_last = (iter_reg == sidec_pkg::ITER_LAST);
    assign status.top_zero  = (top_digit == 4'd0);
    assign status.one_left  = (ndig_reg == sidec_pkg::NDIG_W'(1));
    assign status.negative  = neg_reg;

    assign character = cmd.sign_sel ? sidec_pkg::CHAR_MINUS
                                    : (sidec_pkg::CHAR_ZERO | {4'd0, top_digit});

endmodule

/* rtl/sidec_ctrl.sv */
// ----------------------------------------------------------------------------
// sidec_ctrl
// sequencer: accept, convert, strip leading zeros, emit sign and digits
// ----------------------------------------------------------------------------
module sidec_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_last,
    input  sidec_pkg::dp_status_t  status,
    output sidec_pkg::dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        out_last       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_last)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // leading zeros go, but a lone zero digit stays
                if (status.top_zero && !status.one_left)
                    cmd.digit_step = 1'b1;
                else if (status.negative)
                    state_next = ST_SIGN;
                else
                    state_next = ST_DIGIT;
            end
            ST_SIGN:
            begin
                out_valid    = 1'b1;
                cmd.sign_sel = 1'b1;
                if (out_ready)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                out_valid = 1'b1;
                out_last  = status.one_left;
                if (out_ready)
                begin
                    if (status.one_left)
                        state_next = ST_IDLE;
                    else
                        cmd.digit_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a signed 32-bit integer to its decimal ascii text, one character
// per output transaction, most significant first, tlast on the final one
// ----------------------------------------------------------------------------
// sequence: accept, shift-and-add-3 conversion, leading-zero strip, then the
//   first character is offered; one character per cycle after while m_tready is high
// pacing: set by the shift-and-add-3 loop, one iteration per input bit, and the
//   one-digit-per-cycle output shifter, which holds while m_tready is low; a new
//   integer is accepted only once its text is sent
// reset: asynchronous active-low rst_n returns the sequencer to idle, no
//   output is offered and s_tready is high from reset on
module signed_int_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value, signed two's complement
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] character, ascii '-' or '0'..'9'
    output logic        m_tlast     // last_char: final character of the number
);

    sidec_pkg::dp_cmd_t    cmd;
    sidec_pkg::dp_status_t status;

    // the sequencer owns every handshake; the datapath only follows commands
    sidec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .status    (status),
        .cmd       (cmd)
    );

    // magnitude, binary to bcd, and digit output; the character is decoded from
    // registers that hold steady while a transaction stalls
    sidec_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .character (m_tdata)
    );

endmodule

/* verif/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// streams signed integers into the converter and checks every character
// transaction against text predicted here, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

    // one character transaction as it should appear on the output stream
    typedef struct {
        logic [sidec_pkg::CHAR_W-1:0] character;
        logic                         last_char;
    } char_txn_t;

    // holds the characters still owed by the converter, oldest first
    class decimal_text_board;
        char_txn_t expected_chars[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // an integer was taken in: queue its decimal text
        function void note_value(logic [sidec_pkg::VALUE_W-1:0] value);
            logic [sidec_pkg::VALUE_W-1:0] magnitude;
            logic [sidec_pkg::CHAR_W-1:0]  digit_chars[$];
            char_txn_t                     txn;
            // unsigned magnitude, so the most negative value still works
            magnitude = value[sidec_pkg::VALUE_W-1] ? (32'd0 - value) : value;
            do
            begin
                digit_chars.push_front(sidec_pkg::CHAR_ZERO
                                       + sidec_pkg::CHAR_W'(magnitude % 32'd10));
                magnitude = magnitude / 32'd10;
            end
            while (magnitude != 0);
            if (value[sidec_pkg::VALUE_W-1])
            begin
                txn.character = sidec_pkg::CHAR_MINUS;
                txn.last_char = 1'b0;
                expected_chars.push_back(txn);
            end
            foreach (digit_chars[i])
            begin
                txn.character = digit_chars[i];
                txn.last_char = (i == digit_chars.size() - 1);
                expected_chars.push_back(txn);
            end
        endfunction

        function void check_char(logic [sidec_pkg::CHAR_W-1:0] character,
                                 logic last_char);
            char_txn_t want;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character transaction: character %h last_char %b",
                       character, last_char);
                mismatches++;
                return;
            end
            want = expected_chars.pop_front();
            if (character !== want.character)
            begin
                $error("character mismatch: expected %h actual %h",
                       want.character, character);
                mismatches++;
            end
            if (last_char !== want.last_char)
            begin
                $error("last_char mismatch: expected %b actual %b",
                       want.last_char, last_char);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 410;
    localparam int DRAIN_CYCLES = 64;    // a bit more than the worst conversion

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;     // [31:0] value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;           // [7:0] character
    logic               m_tlast;           // last_char

    decimal_text_board board = new();

    // while set, that side runs back to back with no gaps
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    signed_int_to_decimal_ascii u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // called just after a rising edge; returns at the edge that takes the
    // transaction, so valid is never dropped and raised in one step
    task automatic send_value(input logic [31:0] value);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        // outputs are settled mid-cycle, so the handshake is judged there
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        board.note_value(value);
    endtask

    task automatic take_char();
        int         stall;
        logic [7:0] got_char;
        logic       got_last;
        stall = rx_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 15) == 0)
            rx_calm = !rx_calm;
        if (stall != 0)
        begin
            m_tready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
        do @(negedge clk); while (!m_tvalid);
        got_char = m_tdata;
        got_last = m_tlast;
        @(posedge clk);
        board.check_char(got_char, got_last);
    endtask

    // hold off new integers until every owed character has come out
    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // random integer whose magnitude has a random number of decimal digits,
    // so every text length from one digit to nine digits, with or without a sign, is common
    function automatic logic [31:0] sized_value();
        int          ndig;
        int unsigned bound;
        logic [31:0] magnitude;
        ndig  = $urandom_range(1, 9);
        bound = 1;
        repeat (ndig) bound = bound * 10;
        magnitude = $urandom_range(0, bound - 1);
        return $urandom_range(0, 1) ? (32'd0 - magnitude) : magnitude;
    endfunction

    // output side: accept characters forever once reset is released
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever take_char();
    end

    // input side, then the final verdict
    initial
    begin
        logic [31:0] directed_values[$];
        logic [31:0] value;
        int          pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, one-digit and ten-digit edges, both extremes, carries at
        // powers of ten, alternating bit patterns and every digit
        directed_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10,
                            32'hFFFF_FFF6, 32'd99, 32'd100, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                            32'hC465_3600, 32'd999999999, 32'd1234567890,
                            32'hF8A4_32EB, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'd4294967, 32'd8765432};
        foreach (directed_values[i])
            send_value(directed_values[i]);

        // the sender goes quiet until the text of all directed items is out
        s_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:       value = $urandom();
                1:       value = $urandom() >> $urandom_range(0, 31);
                default: value = sized_value();
            endcase
            send_value(value);
            // now and then let the whole pipeline empty before going on
            if ((n % 100) == 99)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("signed_int_to_decimal_ascii test passed");
        else
            $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #3000000;
        $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

endmodule
